/* rtl/jsu_pkg.sv */
// Shared types, character constants and helper functions for the JSON string unescaper.
package jsu_pkg;

    localparam int CHAR_W  = 21;
    localparam int KIND_W  = 3;
    localparam int HEX_W   = 16;
    localparam int HEXCNT_W = 2;

    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        K_CHAR      = 3'd0,
        K_END       = 3'd1,
        K_BAD_START = 3'd2,
        K_BAD_ESC   = 3'd3,
        K_BAD_HEX   = 3'd4,
        K_UNTERM    = 3'd5
    } kind_t;

    typedef struct packed {
        phase_t                phase;
        logic [HEXCNT_W-1:0]   hex_cnt;
        logic [HEX_W-1:0]      hex_acc;
    } dec_state_t;

    typedef struct packed {
        logic   emit;
        kind_t  kind;
        char_t  value;
    } dec_result_t;

    localparam char_t CH_NUL   = 21'h00;
    localparam char_t CH_QUOTE = 21'h22;
    localparam char_t CH_BSL   = 21'h5C;
    localparam char_t CH_SLASH = 21'h2F;
    localparam char_t CH_B     = 21'h62;
    localparam char_t CH_T     = 21'h74;
    localparam char_t CH_N     = 21'h6E;
    localparam char_t CH_F     = 21'h66;
    localparam char_t CH_R     = 21'h72;
    localparam char_t CH_U     = 21'h75;
    localparam char_t CH_0     = 21'h30;
    localparam char_t CH_9     = 21'h39;
    localparam char_t CH_LA    = 21'h61;
    localparam char_t CH_LF    = 21'h66;
    localparam char_t CH_UA    = 21'h41;
    localparam char_t CH_UF    = 21'h46;

    localparam char_t CTRL_BS  = 21'h08;
    localparam char_t CTRL_TAB = 21'h09;
    localparam char_t CTRL_LF  = 21'h0A;
    localparam char_t CTRL_FF  = 21'h0C;
    localparam char_t CTRL_CR  = 21'h0D;

    // Bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_digit_of(char_t c);
        char_t d;
        logic [4:0] r;
        r = 5'h10;
        d = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            r = d[4:0];
        end
        else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 21'd10;
            r = d[4:0];
        end
        else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 21'd10;
            r = d[4:0];
        end
        return r;
    endfunction

endpackage

/* rtl/jsu_decode.sv */
// Next-state and result logic for one character of a quoted JSON string.
module jsu_decode (
    input  jsu_pkg::dec_state_t  cur,
    input  jsu_pkg::char_t       code,
    output jsu_pkg::dec_state_t  nxt,
    output jsu_pkg::dec_result_t res
);

    logic [4:0]               hv;
    logic [jsu_pkg::HEX_W-1:0] acc_new;

    assign hv      = jsu_pkg::hex_digit_of(code);
    assign acc_new = {cur.hex_acc[jsu_pkg::HEX_W-5:0], hv[3:0]};

    always_comb
    begin
        nxt       = cur;
        res.emit  = 1'b0;
        res.kind  = jsu_pkg::K_CHAR;
        res.value = '0;
        unique case (cur.phase)
            jsu_pkg::PH_IDLE:
            begin
                if (code == jsu_pkg::CH_QUOTE) begin
                    nxt.phase = jsu_pkg::PH_BODY;
                end
                else begin
                    res.emit = 1'b1;
                    res.kind = jsu_pkg::K_BAD_START;
                end
            end
            jsu_pkg::PH_BODY:
            begin
                if (code == jsu_pkg::CH_QUOTE) begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.emit  = 1'b1;
                    res.kind  = jsu_pkg::K_END;
                end
                else if (code == jsu_pkg::CH_NUL) begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.emit  = 1'b1;
                    res.kind  = jsu_pkg::K_UNTERM;
                end
                else if (code == jsu_pkg::CH_BSL) begin
                    nxt.phase = jsu_pkg::PH_ESC;
                end
                else begin
                    res.emit  = 1'b1;
                    res.value = code;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                nxt.phase = jsu_pkg::PH_BODY;
                res.emit  = 1'b1;
                case (code)
                    jsu_pkg::CH_NUL:
                    begin
                        nxt.phase = jsu_pkg::PH_IDLE;
                        res.kind  = jsu_pkg::K_UNTERM;
                    end
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
                        res.value = code;
                    jsu_pkg::CH_B: res.value = jsu_pkg::CTRL_BS;
                    jsu_pkg::CH_T: res.value = jsu_pkg::CTRL_TAB;
                    jsu_pkg::CH_N: res.value = jsu_pkg::CTRL_LF;
                    jsu_pkg::CH_F: res.value = jsu_pkg::CTRL_FF;
                    jsu_pkg::CH_R: res.value = jsu_pkg::CTRL_CR;
                    jsu_pkg::CH_U:
                    begin
                        nxt.phase   = jsu_pkg::PH_HEX;
                        nxt.hex_cnt = '0;
                        nxt.hex_acc = '0;
                        res.emit    = 1'b0;
                    end
                    default:
                    begin
                        nxt.phase = jsu_pkg::PH_IDLE;
                        res.kind  = jsu_pkg::K_BAD_ESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX:
            begin
                if (code == jsu_pkg::CH_NUL) begin
                    nxt.phase   = jsu_pkg::PH_IDLE;
                    nxt.hex_cnt = '0;
                    nxt.hex_acc = '0;
                    res.emit    = 1'b1;
                    res.kind    = jsu_pkg::K_UNTERM;
                end
                else if (hv[4]) begin
                    nxt.phase   = jsu_pkg::PH_IDLE;
                    nxt.hex_cnt = '0;
                    nxt.hex_acc = '0;
                    res.emit    = 1'b1;
                    res.kind    = jsu_pkg::K_BAD_HEX;
                end
                else if (cur.hex_cnt == '1) begin
                    nxt.phase   = jsu_pkg::PH_BODY;
                    nxt.hex_cnt = '0;
                    nxt.hex_acc = '0;
                    res.emit    = 1'b1;
                    res.value   = {{(jsu_pkg::CHAR_W-jsu_pkg::HEX_W){1'b0}}, acc_new};
                end
                else begin
                    nxt.hex_cnt = cur.hex_cnt + 1'b1;
                    nxt.hex_acc = acc_new;
                end
            end
            default:
            begin
                nxt.phase   = jsu_pkg::PH_IDLE;
                nxt.hex_cnt = '0;
                nxt.hex_acc = '0;
            end
        endcase
    end

endmodule

/* rtl/json_string_unescaper.sv */
// Top level of the JSON string unescaper: input register, decoder and result register.
//
// One character code point enters per transfer on the char channel (char_valid,
// char_ready, char_code). The block expects an opening quote, then decodes the
// string body and its escapes, including the four-digit u escape. Each character
// gives at most one result on the result channel (result_valid, result_ready,
// kind, char_value): a decoded character, a string end, or an error code. Errors
// and string ends return the block to waiting for an opening quote.
// A character is first held in the input register; its result is written into
// the result register when the character leaves it. One character is taken
// every cycle while results are being drained, since the decoder is a single
// level of logic between the input register and the result register.
// When the receiver stalls, the result register holds its item and the input
// register holds the next character that would produce a result; the stall then
// reaches char_ready. Characters that give no result still pass through.
// Reset clears both registers' valid flags and the decoder state, leaving the
// block idle and awaiting an opening quote.
module json_string_unescaper (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_ready,
    input  logic [jsu_pkg::CHAR_W-1:0] char_code,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [jsu_pkg::KIND_W-1:0] kind,
    output logic [jsu_pkg::CHAR_W-1:0] char_value
);

    logic                 in_valid_reg;
    jsu_pkg::char_t       in_char_reg;
    jsu_pkg::dec_state_t  state_reg;
    jsu_pkg::dec_state_t  state_next;
    jsu_pkg::dec_result_t res;
    logic                 out_valid_reg;
    jsu_pkg::kind_t       out_kind_reg;
    jsu_pkg::char_t       out_value_reg;
    logic                 out_free;
    logic                 advance;

    jsu_decode u_decode (
        .cur  (state_reg),
        .code (in_char_reg),
        .nxt  (state_next),
        .res  (res)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign advance    = in_valid_reg && (!res.emit || out_free);
    assign char_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{phase: jsu_pkg::PH_IDLE, hex_cnt: '0, hex_acc: '0};
            out_valid_reg <= 1'b0;
        end
        else begin
            if (char_ready) begin
                in_valid_reg <= char_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && res.emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid) begin
            in_char_reg <= char_code;
        end
        if (advance && res.emit) begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign char_value   = out_value_reg;

    // A hex digit count or partial code only exists while gathering hex digits.
    a_hex_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.hex_cnt != '0) |-> (state_reg.phase == jsu_pkg::PH_HEX))
        else $error("hex digit count outside hex phase");

    a_hex_acc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.hex_acc != '0) |-> (state_reg.phase == jsu_pkg::PH_HEX))
        else $error("hex accumulator outside hex phase");

    // Every end or error result leaves the decoder idle.
    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.emit && res.kind != jsu_pkg::K_CHAR)
        |=> (state_reg.phase == jsu_pkg::PH_IDLE))
        else $error("decoder not idle after end or error");

    // Non-character results carry a zero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != jsu_pkg::K_CHAR) |-> (out_value_reg == '0))
        else $error("non-character result with non-zero value");

    // A new result is never written over one still waiting for its transfer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !(advance && res.emit))
        else $error("result register overwritten while stalled");

endmodule
